// ===== sv/esd_pkg.sv =====
// Shared types, constants and a lookup function for the epoch seconds to date/time pipeline.
package esd_pkg;

    // Pipeline shape: day split stages, then the parallel date and time-of-day stages
    localparam int DAY_STAGES  = 3;
    localparam int DATE_STAGES = 8;
    localparam int PIPE_STAGES = DAY_STAGES + DATE_STAGES;

    // Seconds to days: (secs >> 7) / 675, estimate by floor(2^32 / 675) and correct once
    localparam logic [22:0] DAY_RECIP = 23'd6362914;
    localparam logic [9:0]  DAY_DIV   = 10'd675;

    // Julian day of the epoch plus the 32044 offset of the date algorithm
    localparam logic [21:0] JDN_OFFSET = 22'd2483589;

    // 400-year period: estimate by floor(2^32 / 146097) and correct once
    localparam logic [14:0] CENT_RECIP = 15'd29398;
    localparam logic [17:0] CENT_DIV   = 18'd146097;

    // 4-year period: estimate by floor(2^26 / 1461) and correct once
    localparam logic [15:0] QUAD_RECIP = 16'd45933;
    localparam logic [10:0] QUAD_DIV   = 11'd1461;

    // Month index: (5e + 2) / 153, exact by ceil(2^18 / 153)
    localparam logic [10:0] MON_RECIP = 11'd1714;

    // Time of day: (tod >> 4) / 225 and (rem >> 2) / 15, exact reciprocals
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam logic [5:0]  SEC_PER_MIN = 6'd60;

    // Year bias of the date algorithm
    localparam logic [13:0] YEAR_BIAS = 14'd4800;

    typedef logic [15:0] day_count_t;
    typedef logic [16:0] tod_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } ymd_t;

    // Day of the March-based year on which month index m starts: (153m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] start;
        unique case (m)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ===== sv/esd_day_split.sv =====
// Splits the seconds count into whole days and seconds of the day over three stages.
module esd_day_split (
    input  logic                              aclk,
    input  logic [esd_pkg::DAY_STAGES-1:0]    load,
    input  logic [31:0]                       packed_seconds,
    output esd_pkg::day_count_t               days,
    output esd_pkg::tod_t                     tod
);
    import esd_pkg::*;

    logic [15:0] quot_reg;
    logic [31:0] secs0_reg;
    logic [25:0] back_reg;
    logic [15:0] quot1_reg;
    logic [31:0] secs1_reg;
    day_count_t  days_reg;
    tod_t        tod_reg;

    logic [47:0] recip_prod;
    logic [25:0] back_next;
    logic [25:0] rem_full;
    logic [10:0] rem;
    logic        fix;
    logic [10:0] rem_fixed;
    day_count_t  days_next;
    tod_t        tod_next;

    // Estimate the quotient by reciprocal multiply
    assign recip_prod = 48'(packed_seconds[31:7]) * 48'(DAY_RECIP);

    // Multiply the estimate back
    assign back_next = 26'(quot_reg) * 26'(DAY_DIV);

    // Correct the estimate by one compare and subtract
    assign rem_full  = 26'(secs1_reg[31:7]) - back_reg;
    assign rem       = rem_full[10:0];
    assign fix       = (rem >= 11'(DAY_DIV));
    assign rem_fixed = fix ? (rem - 11'(DAY_DIV)) : rem;
    assign days_next = quot1_reg + 16'(fix);
    assign tod_next  = {rem_fixed[9:0], secs1_reg[6:0]};

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            quot_reg  <= recip_prod[47:32];
            secs0_reg <= packed_seconds;
        end
        if (load[1]) begin
            back_reg  <= back_next;
            quot1_reg <= quot_reg;
            secs1_reg <= secs0_reg;
        end
        if (load[2]) begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
    end

    assign days = days_reg;
    assign tod  = tod_reg;

endmodule

// ===== sv/esd_time_split.sv =====
// Splits seconds of the day into hour, minute and second, delayed to match the date path.
module esd_time_split (
    input  logic                              aclk,
    input  logic [esd_pkg::DATE_STAGES-1:0]   load,
    input  esd_pkg::tod_t                     tod,
    output esd_pkg::hms_t                     hms
);
    import esd_pkg::*;

    localparam int DELAY = DATE_STAGES - 3;

    logic [4:0]  hour0_reg;
    tod_t        tod0_reg;
    logic [16:0] hsec_reg;
    logic [4:0]  hour1_reg;
    tod_t        tod1_reg;
    logic [11:0] rem_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour2_reg;
    hms_t        hms_reg [DELAY];

    logic [24:0] hour_prod;
    logic [16:0] hsec_next;
    logic [16:0] rem_full;
    logic [11:0] rem_next;
    logic [19:0] min_prod;
    logic [11:0] msec;
    logic [11:0] sec_full;
    hms_t        hms_next;

    // Hour by exact reciprocal
    assign hour_prod = 25'(tod[16:4]) * 25'(HOUR_RECIP);

    // Seconds in the whole hours
    assign hsec_next = 17'(hour0_reg) * 17'(SEC_PER_HOUR);

    // Remainder within the hour, then minute by exact reciprocal
    assign rem_full = tod1_reg - hsec_reg;
    assign rem_next = rem_full[11:0];
    assign min_prod = 20'(rem_next[11:2]) * 20'(MIN_RECIP);

    // Second within the minute
    assign msec     = 12'(minute_reg) * 12'(SEC_PER_MIN);
    assign sec_full = rem_reg - msec;
    assign hms_next = '{hour: hour2_reg, minute: minute_reg, second: sec_full[5:0]};

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            hour0_reg <= hour_prod[24:20];
            tod0_reg  <= tod;
        end
        if (load[1]) begin
            hsec_reg  <= hsec_next;
            hour1_reg <= hour0_reg;
            tod1_reg  <= tod0_reg;
        end
        if (load[2]) begin
            rem_reg    <= rem_next;
            minute_reg <= min_prod[19:14];
            hour2_reg  <= hour1_reg;
        end
        if (load[3]) begin
            hms_reg[0] <= hms_next;
        end
        // Hold the result alongside the date stages
        for (int i = 1; i < DELAY; i++) begin
            if (load[i + 3]) begin
                hms_reg[i] <= hms_reg[i - 1];
            end
        end
    end

    assign hms = hms_reg[DELAY - 1];

endmodule

// ===== sv/esd_jdn_to_date.sv =====
// Turns a day count into a Gregorian year, month and day through the Julian day number.
module esd_jdn_to_date (
    input  logic                              aclk,
    input  logic [esd_pkg::DATE_STAGES-1:0]   load,
    input  esd_pkg::day_count_t               days,
    output esd_pkg::ymd_t                     ymd
);
    import esd_pkg::*;

    // 400-year period stages
    logic [38:0] cent_prod;
    logic [23:0] num_next;
    logic [6:0]  b0_reg;
    logic [23:0] num0_reg;
    logic [23:0] bback_reg;
    logic [6:0]  b1_reg;
    logic [23:0] num1_reg;
    logic [23:0] bback_next;
    logic [23:0] crem_full;
    logic [18:0] crem;
    logic        cfix;
    logic [18:0] crem_fixed;
    logic [6:0]  b_next;
    logic [6:0]  b2_reg;
    logic [15:0] c_reg;

    // 4-year period stages
    logic [17:0] num2_next;
    logic [32:0] quad_prod;
    logic [6:0]  d0_reg;
    logic [17:0] num2_reg;
    logic [6:0]  b3_reg;
    logic [17:0] dback_next;
    logic [17:0] dback_reg;
    logic [6:0]  d1_reg;
    logic [17:0] num3_reg;
    logic [6:0]  b4_reg;
    logic [17:0] drem_full;
    logic [11:0] drem;
    logic        dfix;
    logic [11:0] drem_fixed;
    logic [6:0]  d_next;
    logic [6:0]  d2_reg;
    logic [8:0]  e_reg;
    logic [6:0]  b5_reg;

    // Month index and final fields
    logic [10:0] mnum;
    logic [21:0] mon_prod;
    logic [3:0]  m_reg;
    logic [8:0]  e1_reg;
    logic [6:0]  d3_reg;
    logic [6:0]  b6_reg;
    logic        wrap;
    logic [13:0] year_full;
    logic [8:0]  day_full;
    ymd_t        ymd_next;
    ymd_t        ymd_reg;

    // Offset the day count and estimate the 400-year quotient
    assign num_next  = {22'(days) + JDN_OFFSET, 2'b11};
    assign cent_prod = 39'(num_next) * 39'(CENT_RECIP);

    // Multiply the estimate back
    assign bback_next = 24'(b0_reg) * 24'(CENT_DIV);

    // Correct the estimate; the day of the period is the remainder over four
    assign crem_full  = num1_reg - bback_reg;
    assign crem       = crem_full[18:0];
    assign cfix       = (crem >= 19'(CENT_DIV));
    assign crem_fixed = cfix ? (crem - 19'(CENT_DIV)) : crem;
    assign b_next     = b1_reg + 7'(cfix);

    // Estimate the 4-year quotient
    assign num2_next = {c_reg, 2'b11};
    assign quad_prod = 33'(num2_next) * 33'(QUAD_RECIP);

    // Multiply the estimate back
    assign dback_next = 18'(d0_reg) * 18'(QUAD_DIV);

    // Correct the estimate; the day of the year is the remainder over four
    assign drem_full  = num3_reg - dback_reg;
    assign drem       = drem_full[11:0];
    assign dfix       = (drem >= 12'(QUAD_DIV));
    assign drem_fixed = dfix ? (drem - 12'(QUAD_DIV)) : drem;
    assign d_next     = d1_reg + 7'(dfix);

    // Month index of the March-based year
    assign mnum     = 11'(e_reg) * 11'd5 + 11'd2;
    assign mon_prod = 22'(mnum) * 22'(MON_RECIP);

    // Assemble year, month and day; January and February belong to the next year
    assign wrap      = (m_reg >= 4'd10);
    assign year_full = 14'(b6_reg) * 14'd100 + 14'(d3_reg) + 14'(wrap) - YEAR_BIAS;
    assign day_full  = e1_reg - month_start(m_reg) + 9'd1;
    assign ymd_next  = '{year:  year_full[11:0],
                         month: wrap ? (m_reg - 4'd9) : (m_reg + 4'd3),
                         day:   day_full[4:0]};

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            b0_reg   <= cent_prod[38:32];
            num0_reg <= num_next;
        end
        if (load[1]) begin
            bback_reg <= bback_next;
            b1_reg    <= b0_reg;
            num1_reg  <= num0_reg;
        end
        if (load[2]) begin
            b2_reg <= b_next;
            c_reg  <= crem_fixed[17:2];
        end
        if (load[3]) begin
            d0_reg   <= quad_prod[32:26];
            num2_reg <= num2_next;
            b3_reg   <= b2_reg;
        end
        if (load[4]) begin
            dback_reg <= dback_next;
            d1_reg    <= d0_reg;
            num3_reg  <= num2_reg;
            b4_reg    <= b3_reg;
        end
        if (load[5]) begin
            d2_reg <= d_next;
            e_reg  <= drem_fixed[10:2];
            b5_reg <= b4_reg;
        end
        if (load[6]) begin
            m_reg  <= mon_prod[21:18];
            e1_reg <= e_reg;
            d3_reg <= d2_reg;
            b6_reg <= b5_reg;
        end
        if (load[7]) begin
            ymd_reg <= ymd_next;
        end
    end

    assign ymd = ymd_reg;

endmodule

// ===== sv/epoch_seconds_to_datetime.sv =====
// Top level: seconds since 2000-01-01 00:00:00 to calendar date and time of day.
//
// Each accepted count of seconds gives one result with year, month, day, hour,
// minute and second. The block is an 11-stage pipeline: three stages split the
// count into whole days and seconds of the day, then eight stages run the
// Julian-day-to-Gregorian date steps beside the hour/minute/second split. A
// new count is taken every cycle when the output is not stalled. Every constant
// division is a reciprocal multiply followed, where needed, by one
// compare-and-subtract stage; the two multiply-then-correct passes of the date
// steps set the depth. A stall on m_ready holds each occupied stage that has no
// empty stage after it, and empty stages keep filling, so s_ready drops only
// when every stage holds a result.
module epoch_seconds_to_datetime (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_packed_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);
    import esd_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES:0]   stage_ready;
    logic [PIPE_STAGES-1:0] valid_next;
    day_count_t             days;
    tod_t                   tod;
    hms_t                   hms;
    ymd_t                   ymd;

    // A stage may load when it is empty or its content moves on
    always_comb begin
        stage_ready[PIPE_STAGES] = m_ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i + 1];
        end
    end

    // Advance the valid bits with the data
    always_comb begin
        valid_next = valid_reg;
        if (stage_ready[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (stage_ready[i]) begin
                valid_next[i] = valid_reg[i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    esd_day_split u_day_split (
        .aclk           (aclk),
        .load           (stage_ready[DAY_STAGES-1:0]),
        .packed_seconds (s_packed_seconds),
        .days           (days),
        .tod            (tod)
    );

    esd_jdn_to_date u_jdn_to_date (
        .aclk (aclk),
        .load (stage_ready[PIPE_STAGES-1:DAY_STAGES]),
        .days (days),
        .ymd  (ymd)
    );

    esd_time_split u_time_split (
        .aclk (aclk),
        .load (stage_ready[PIPE_STAGES-1:DAY_STAGES]),
        .tod  (tod),
        .hms  (hms)
    );

    // Drive the transfer handshake and result fields
    assign s_ready  = stage_ready[0];
    assign m_valid  = valid_reg[PIPE_STAGES-1];
    assign m_year   = ymd.year;
    assign m_month  = ymd.month;
    assign m_day    = ymd.day;
    assign m_hour   = hms.hour;
    assign m_minute = hms.minute;
    assign m_second = hms.second;

endmodule
